### rtl/accel_tilt_angle_and_level_flags_defines.svh
// Assertion macros used by the checker file of the tilt angle block.
// No dependencies.
`ifndef ACCEL_TILT_ANGLE_AND_LEVEL_FLAGS_DEFINES_SVH
`define ACCEL_TILT_ANGLE_AND_LEVEL_FLAGS_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ATA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define ATA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/ata_pkg.sv
// Package of the tilt angle block: widths, constants, arctangent table.
// No dependencies; used by all modules of the block.
`default_nettype none

package ata_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int TILT_W        = 11;
    localparam int THRESH_W      = 15;
    localparam int ITER_DEFAULT  = 16;
    localparam int ITER_MAX      = 24;
    localparam int SQRT_STAGES   = 24;
    localparam int ROOT_W        = 24;
    localparam int REM_W         = 25;
    localparam int XY_W          = 27;
    localparam int Z_W           = 28;
    localparam int ATAN_W        = 26;
    localparam int IN_DATA_W     = 48;
    localparam int OUT_DATA_W    = 40;
    localparam int TILT_LIMIT    = 900;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd2000;

    typedef struct packed {
        logic y_above;
        logic y_below;
        logic x_above;
        logic x_below;
    } t_flags;

    // atan(2^-i) in 1/65536 of a tenth of a degree
    function automatic logic [ATAN_W-1:0] atan_step(input int idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            0:       v = 26'd29491200;
            1:       v = 26'd17409672;
            2:       v = 26'd9198793;
            3:       v = 26'd4669451;
            4:       v = 26'd2343787;
            5:       v = 26'd1173036;
            6:       v = 26'd586661;
            7:       v = 26'd293348;
            8:       v = 26'd146676;
            9:       v = 26'd73339;
            10:      v = 26'd36669;
            11:      v = 26'd18335;
            12:      v = 26'd9167;
            13:      v = 26'd4584;
            14:      v = 26'd2292;
            15:      v = 26'd1146;
            16:      v = 26'd573;
            17:      v = 26'd286;
            18:      v = 26'd143;
            19:      v = 26'd72;
            20:      v = 26'd36;
            21:      v = 26'd18;
            22:      v = 26'd9;
            23:      v = 26'd4;
            default: v = '0;
        endcase
        return v;
    endfunction

    // squares, sum, root stages, rotation stages, rounding
    function automatic int lane_latency(input int iters);
        return 3 + SQRT_STAGES + iters;
    endfunction

endpackage

`default_nettype wire

### rtl/ata_lane.sv
// One tilt lane: atan(a / sqrt(b*b + c*c)) through a pipelined root and
// pipelined vectoring rotations. Depends on ata_pkg.
`default_nettype none

module ata_lane #(
    parameter int ITERS = ata_pkg::ITER_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic signed [ata_pkg::SAMPLE_W-1:0] i_a,
    input  wire logic signed [ata_pkg::SAMPLE_W-1:0] i_b,
    input  wire logic signed [ata_pkg::SAMPLE_W-1:0] i_c,
    output logic signed [ata_pkg::TILT_W-1:0]        o_tilt
);

    localparam int SQ = ata_pkg::SQRT_STAGES;

    typedef struct packed {
        logic signed [ata_pkg::SAMPLE_W-1:0] a;
        logic                                zero;
        logic signed [ata_pkg::TILT_W-1:0]   forced;
    } t_side;

    logic [31:0]                       r_bb, r_cc;
    logic signed [ata_pkg::SAMPLE_W-1:0] r_a0;
    logic                              r_zero0;
    logic [31:0]                       r_s    [0:SQ];
    logic [ata_pkg::REM_W-1:0]         r_rem  [0:SQ];
    logic [ata_pkg::ROOT_W-1:0]        r_root [0:SQ];
    t_side                             r_side [0:SQ];
    logic signed [ata_pkg::XY_W-1:0]   cx [0:ITERS];
    logic signed [ata_pkg::XY_W-1:0]   cy [0:ITERS];
    logic signed [ata_pkg::Z_W-1:0]    cz [0:ITERS];
    t_side                             cs [0:ITERS];
    logic signed [ata_pkg::Z_W-1:0]    zr;
    logic signed [11:0]                t12;
    logic signed [ata_pkg::TILT_W-1:0] clamped;
    logic signed [ata_pkg::TILT_W-1:0] r_tilt;
    logic signed [ata_pkg::TILT_W-1:0] n_forced;

    // squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bb    <= 32'(i_b * i_b);
            r_cc    <= 32'(i_c * i_c);
            r_a0    <= i_a;
            r_zero0 <= (i_b == '0) && (i_c == '0);
        end
    end

    always_comb begin
        if (r_a0 > 0)
            n_forced = ata_pkg::TILT_W'(ata_pkg::TILT_LIMIT);
        else if (r_a0 < 0)
            n_forced = -ata_pkg::TILT_W'(ata_pkg::TILT_LIMIT);
        else
            n_forced = '0;
    end

    // sum of squares, root seed
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0]    <= r_bb + r_cc;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= '{a: r_a0, zero: r_zero0, forced: n_forced};
        end
    end

    // root of s * 2^16, two radicand bits per stage
    for (genvar j = 1; j <= SQ; j++) begin : g_sqrt
        localparam int HI = 47 - 2 * (j - 1);
        logic [47:0] v;
        logic [ata_pkg::REM_W+1:0] cur, trial, diff;
        logic ge;
        assign v     = {r_s[j-1], 16'b0};
        assign cur   = {r_rem[j-1], v[HI -: 2]};
        assign trial = {1'b0, r_root[j-1], 2'b01};
        assign ge    = cur >= trial;
        assign diff  = cur - trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[j]    <= r_s[j-1];
                r_rem[j]  <= ge ? diff[ata_pkg::REM_W-1:0] : cur[ata_pkg::REM_W-1:0];
                r_root[j] <= {r_root[j-1][ata_pkg::ROOT_W-2:0], ge};
                r_side[j] <= r_side[j-1];
            end
        end
    end

    assign cx[0] = $signed({3'b0, r_root[SQ]});
    assign cy[0] = $signed({{3{r_side[SQ].a[ata_pkg::SAMPLE_W-1]}}, r_side[SQ].a, 8'b0});
    assign cz[0] = '0;
    assign cs[0] = r_side[SQ];

    // vectoring rotations, one per stage
    for (genvar i = 0; i < ITERS; i++) begin : g_rot
        logic signed [ata_pkg::XY_W-1:0] dx, dy, r_x, r_y;
        logic signed [ata_pkg::Z_W-1:0]  ang, r_z;
        t_side r_sd;
        logic  pos;
        assign dx  = cy[i] >>> i;
        assign dy  = cx[i] >>> i;
        assign pos = !cy[i][ata_pkg::XY_W-1];
        assign ang = $signed({2'b0, ata_pkg::atan_step(i)});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x  <= pos ? cx[i] + dx : cx[i] - dx;
                r_y  <= pos ? cy[i] - dy : cy[i] + dy;
                r_z  <= pos ? cz[i] + ang : cz[i] - ang;
                r_sd <= cs[i];
            end
        end
        assign cx[i+1] = r_x;
        assign cy[i+1] = r_y;
        assign cz[i+1] = r_z;
        assign cs[i+1] = r_sd;
    end

    // round to tenths and clamp
    assign zr  = cz[ITERS] + ata_pkg::Z_W'(32768);
    assign t12 = zr[ata_pkg::Z_W-1:16];
    always_comb begin
        if (t12 > 12'sd900)
            clamped = ata_pkg::TILT_W'(ata_pkg::TILT_LIMIT);
        else if (t12 < -12'sd900)
            clamped = -ata_pkg::TILT_W'(ata_pkg::TILT_LIMIT);
        else
            clamped = t12[ata_pkg::TILT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tilt <= cs[ITERS].zero ? cs[ITERS].forced : clamped;
        end
    end

    assign o_tilt = r_tilt;

endmodule

`default_nettype wire

### rtl/ata_merge.sv
// Merge stage: tracks occupancy and level flags alongside the lanes and
// packs the three tilts and flags into the output register. Uses ata_pkg.
`default_nettype none

module ata_merge #(
    parameter int LAT = ata_pkg::lane_latency(ata_pkg::ITER_DEFAULT)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_accept,
    input  wire ata_pkg::t_flags                    i_flags,
    input  wire logic signed [ata_pkg::TILT_W-1:0]  i_tilt_x,
    input  wire logic signed [ata_pkg::TILT_W-1:0]  i_tilt_y,
    input  wire logic signed [ata_pkg::TILT_W-1:0]  i_tilt_z,
    input  wire logic                               i_m_tready,
    output logic                                    o_en,
    output logic                                    o_m_tvalid,
    output logic [ata_pkg::OUT_DATA_W-1:0]          o_m_tdata
);

    logic            r_vld [0:LAT-1];
    ata_pkg::t_flags r_flg [0:LAT-1];
    logic            r_out_valid;
    logic [ata_pkg::OUT_DATA_W-1:0] r_data;

    assign o_en = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_en) begin
            r_vld[0] <= i_accept;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
            r_out_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_flg[0] <= i_flags;
            for (int k = 1; k < LAT; k++) r_flg[k] <= r_flg[k-1];
            r_data <= {3'b0, r_flg[LAT-1], i_tilt_z, i_tilt_y, i_tilt_x};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_data;

endmodule

`default_nettype wire

### rtl/accel_tilt_angle_and_level_flags.sv
// Top level of the accelerometer tilt angle and level flag block.
// Depends on ata_pkg, ata_lane and ata_merge.
//
//  Channel   Direction  Payload (lowest bit up)
//  s_axis    in         accel_x, accel_y, accel_z (16 b signed each)
//  m_axis    out        tilt_x, tilt_y, tilt_z (11 b signed), x_below,
//                       x_above, y_below, y_above, 3 zero pad bits
//  cfg       in         level_threshold (15 b)
//
// One sample enters per cycle while no result is held; each result passes
// through the squares, the sum, 24 root stages, one stage per rotation,
// rounding and the output register. The 24-stage root pipeline and the
// rotation chain set the latency of a result.
// Reset is synchronous, active low; it clears occupancy and the output valid
// and restores the threshold to 2000.
// A held result stalls the whole pipeline; s_axis tready drops only then.
`default_nettype none

module accel_tilt_angle_and_level_flags #(
    parameter int ANGLE_ITERATIONS = ata_pkg::ITER_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // accel_x, accel_y, accel_z
    input  wire logic [ata_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // tilt_x, tilt_y, tilt_z, x_below, x_above, y_below, y_above, pad
    output logic [ata_pkg::OUT_DATA_W-1:0]         o_m_axis_tdata,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ata_pkg::THRESH_W-1:0]      i_cfg_data
);

    localparam int LAT = ata_pkg::lane_latency(ANGLE_ITERATIONS);

    logic [ata_pkg::THRESH_W-1:0]        r_thresh;
    logic signed [ata_pkg::SAMPLE_W-1:0] ax, ay, az;
    logic signed [ata_pkg::SAMPLE_W:0]   ex, ey, th_pos, th_neg;
    ata_pkg::t_flags                     flags;
    logic                                en, accept;
    logic signed [ata_pkg::TILT_W-1:0]   tilt_x, tilt_y, tilt_z;

    // threshold register; the user must write it only while idle (not enforced)
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= ata_pkg::THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_thresh <= i_cfg_data;
        end
    end

    assign ax = i_s_axis_tdata[15:0];
    assign ay = i_s_axis_tdata[31:16];
    assign az = i_s_axis_tdata[47:32];

    // compare on 17 bits so minus threshold never wraps
    assign ex     = {ax[15], ax};
    assign ey     = {ay[15], ay};
    assign th_pos = $signed({2'b0, r_thresh});
    assign th_neg = -th_pos;

    assign flags.x_below = ex < th_neg;
    assign flags.x_above = ex > th_pos;
    assign flags.y_below = ey < th_neg;
    assign flags.y_above = ey > th_pos;

    assign o_s_axis_tready = en;
    assign accept          = i_s_axis_tvalid && en;

    // one lane per axis: numerator axis, then the two others
    ata_lane #(.ITERS(ANGLE_ITERATIONS)) u_lane_x (
        .i_clk(i_clk), .i_en(en), .i_a(ax), .i_b(ay), .i_c(az), .o_tilt(tilt_x)
    );
    ata_lane #(.ITERS(ANGLE_ITERATIONS)) u_lane_y (
        .i_clk(i_clk), .i_en(en), .i_a(ay), .i_b(ax), .i_c(az), .o_tilt(tilt_y)
    );
    ata_lane #(.ITERS(ANGLE_ITERATIONS)) u_lane_z (
        .i_clk(i_clk), .i_en(en), .i_a(az), .i_b(ax), .i_c(ay), .o_tilt(tilt_z)
    );

    ata_merge #(.LAT(LAT)) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_flags    (flags),
        .i_tilt_x   (tilt_x),
        .i_tilt_y   (tilt_y),
        .i_tilt_z   (tilt_z),
        .i_m_tready (i_m_axis_tready),
        .o_en       (en),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

### rtl/ata_checker.sv
// Port-level checks of the tilt angle block and their bind.
// Depends on ata_pkg and the block's defines header.
`default_nettype none
`include "accel_tilt_angle_and_level_flags_defines.svh"

module ata_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_s_tready,
    input wire logic                           i_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [ata_pkg::OUT_DATA_W-1:0] i_m_tdata
);

    logic                              held;
    logic signed [ata_pkg::TILT_W-1:0] tilt_x;
    logic                              band_ok;
    logic                              range_ok;

    assign held     = i_m_tvalid && !i_m_tready;
    assign tilt_x   = i_m_tdata[10:0];
    assign band_ok  = !(i_m_tdata[33] && i_m_tdata[34]) && !(i_m_tdata[35] && i_m_tdata[36]);
    assign range_ok = (tilt_x <= 11'sd900) && (tilt_x >= -11'sd900);

    // a held transaction keeps its payload
    `ATA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, held, i_m_tvalid && $stable(i_m_tdata))

    // an empty output register never blocks the input
    `ATA_ASSERT_IMPL(a_free, i_clk, i_rst_n, !i_m_tvalid, i_s_tready)

    // a sample cannot lie both below and above the band
    `ATA_ASSERT_IMPL(a_band, i_clk, i_rst_n, i_m_tvalid, band_ok)

    // tilt_x stays within plus or minus ninety degrees
    `ATA_ASSERT_IMPL(a_range, i_clk, i_rst_n, i_m_tvalid, range_ok)

endmodule

bind accel_tilt_angle_and_level_flags ata_checker u_ata_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);

`default_nettype wire
